// File: design/dhtk_pkg.sv
// ----------------------------------------------------------------------------
// dhtk_pkg
// Types, constants and helper functions shared by the key parser modules.
// ----------------------------------------------------------------------------
package dhtk_pkg;

  localparam int unsigned DefIdBytes = 32;
  localparam int unsigned PrefixLen  = 5;
  localparam int unsigned SepLen     = 6;
  localparam int unsigned StoreAw    = 4;   // word slots per bank, as address bits
  localparam int unsigned NumBanks   = 2;
  localparam int unsigned CmdDepth   = NumBanks;
  localparam int unsigned ResDepth   = 4;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_key;
  } item_t;

  typedef struct packed {
    logic        status;
    logic [2:0]  word_seq;
    logic [63:0] word;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic ok;
    logic bank;
  } cmd_t;

  typedef struct packed {
    logic               en;
    logic [StoreAw:0]   addr;   // bank bit on top
    logic [63:0]        data;
  } wr_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } nib_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h6d;  // m
      3'd1:    c = 8'h67;  // g
      3'd2:    c = 8'h6d;  // m
      3'd3:    c = 8'h74;  // t
      3'd4:    c = 8'h3a;  // :
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] sep_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h3a;  // :
      3'd1:    c = 8'h6e;  // n
      3'd2:    c = 8'h6f;  // o
      3'd3:    c = 8'h64;  // d
      3'd4:    c = 8'h65;  // e
      3'd5:    c = 8'h3a;  // :
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic nib_t hex_nibble(input logic [7:0] c);
    nib_t n;
    n = '{ok: 1'b0, val: 4'h0};
    if (c >= 8'h30 && c <= 8'h39) begin
      n.ok  = 1'b1;
      n.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      n.ok  = 1'b1;
      n.val = 4'(c - 8'h57);
    end
    return n;
  endfunction

endpackage

// File: design/dhtk_fifo.sv
// ----------------------------------------------------------------------------
// dhtk_fifo
// Small register queue; Depth must be a power of two.
// ----------------------------------------------------------------------------
module dhtk_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [Width-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth+1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign do_push = push_i && (cnt_q != CntW'(Depth));
  assign do_pop  = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= PtrW'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= PtrW'(rd_ptr_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= CntW'(cnt_q + 1'b1);
      end else if (do_pop && !do_push) begin
        cnt_q <= CntW'(cnt_q - 1'b1);
      end
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

// File: design/dhtk_front.sv
// ----------------------------------------------------------------------------
// dhtk_front
// Per-character parse: position count, literal checks, hex decode into words.
// ----------------------------------------------------------------------------
module dhtk_front #(
  parameter int unsigned ID_BYTES = dhtk_pkg::DefIdBytes
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  dhtk_pkg::item_t item_i,
  output dhtk_pkg::wr_t   wr_o,
  output logic            cmd_push_o,
  output dhtk_pkg::cmd_t  cmd_o
);

  localparam int unsigned HexLen     = 2 * ID_BYTES;
  localparam int unsigned MeshStart  = dhtk_pkg::PrefixLen;
  localparam int unsigned SepStart   = MeshStart + HexLen;
  localparam int unsigned OwnerStart = SepStart + dhtk_pkg::SepLen;
  localparam int unsigned KeyLen     = OwnerStart + HexLen;
  localparam int unsigned WordsPerId = (ID_BYTES + 7) / 8;
  localparam int unsigned PosW       = $clog2(KeyLen + 1);
  localparam int unsigned DigW       = $clog2(HexLen);
  localparam int unsigned ByteW      = DigW - 1;

  localparam logic [PosW-1:0]  KeyLenP     = PosW'(KeyLen);
  localparam logic [PosW-1:0]  MeshStartP  = PosW'(MeshStart);
  localparam logic [PosW-1:0]  SepStartP   = PosW'(SepStart);
  localparam logic [PosW-1:0]  OwnerStartP = PosW'(OwnerStart);
  localparam logic [ByteW-1:0] LastByteP   = ByteW'(ID_BYTES - 1);

  logic [PosW-1:0] pos_q, pos_d;
  logic            bad_q, bad_d;
  logic [3:0]      hi_q, hi_d;
  logic            mesh_nz_q, mesh_nz_d;
  logic            owner_nz_q, owner_nz_d;
  logic            bank_q, bank_d;
  logic [63:0]     acc_q, acc_d;

  logic [PosW-1:0]  pre_off, sep_off, mesh_off, owner_off;
  logic [DigW-1:0]  digit;
  logic [ByteW-1:0] byte_idx;
  logic [2:0]       lane;
  logic [3:0]       word_idx;
  logic [7:0]       byte_val;
  logic             is_owner;
  logic             ok_key;
  dhtk_pkg::nib_t   nib;

  always_comb begin
    pos_d      = pos_q;
    bad_d      = bad_q;
    hi_d       = hi_q;
    mesh_nz_d  = mesh_nz_q;
    owner_nz_d = owner_nz_q;
    bank_d     = bank_q;
    acc_d      = acc_q;
    wr_o       = '{en: 1'b0, addr: '0, data: '0};
    cmd_push_o = 1'b0;
    ok_key     = 1'b0;

    pre_off   = pos_q;
    sep_off   = PosW'(pos_q - SepStartP);
    mesh_off  = PosW'(pos_q - MeshStartP);
    owner_off = PosW'(pos_q - OwnerStartP);
    is_owner  = (pos_q >= OwnerStartP);
    digit     = is_owner ? owner_off[DigW-1:0] : mesh_off[DigW-1:0];
    byte_idx  = digit[DigW-1:1];
    lane      = byte_idx[2:0];
    word_idx  = 4'(is_owner ? WordsPerId : 0) + 4'(byte_idx >> 3);
    nib       = dhtk_pkg::hex_nibble(item_i.character);
    if (!nib.ok) begin
      nib.val = 4'h0;
    end
    byte_val  = {hi_q, nib.val};

    if (take_i) begin
      if (pos_q >= KeyLenP) begin
        bad_d = 1'b1;
      end else begin
        pos_d = PosW'(pos_q + 1'b1);
        priority if (pos_q < MeshStartP) begin
          if (item_i.character != dhtk_pkg::prefix_char(pre_off[2:0])) begin
            bad_d = 1'b1;
          end
        end else if (pos_q >= SepStartP && pos_q < OwnerStartP) begin
          if (item_i.character != dhtk_pkg::sep_char(sep_off[2:0])) begin
            bad_d = 1'b1;
          end
        end else begin
          if (!nib.ok) begin
            bad_d = 1'b1;
          end
          if (!digit[0]) begin
            hi_d = nib.val;
          end else begin
            acc_d = ((lane == 3'd0) ? 64'h0 : acc_q)
                  | (64'(byte_val) << {3'd7 - lane, 3'b000});
            if (lane == 3'd7 || byte_idx == LastByteP) begin
              wr_o = '{en: 1'b1, addr: {bank_q, word_idx}, data: acc_d};
            end
            if (byte_val != 8'h00) begin
              if (is_owner) begin
                owner_nz_d = 1'b1;
              end else begin
                mesh_nz_d = 1'b1;
              end
            end
          end
        end
      end

      if (item_i.end_of_key) begin
        ok_key     = !bad_d && (pos_d == KeyLenP) && mesh_nz_d && owner_nz_d;
        cmd_push_o = 1'b1;
        pos_d      = '0;
        bad_d      = 1'b0;
        hi_d       = 4'h0;
        mesh_nz_d  = 1'b0;
        owner_nz_d = 1'b0;
        bank_d     = !bank_q;
      end
    end
  end

  assign cmd_o = '{ok: ok_key, bank: bank_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      bad_q      <= 1'b0;
      hi_q       <= 4'h0;
      mesh_nz_q  <= 1'b0;
      owner_nz_q <= 1'b0;
      bank_q     <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      bad_q      <= bad_d;
      hi_q       <= hi_d;
      mesh_nz_q  <= mesh_nz_d;
      owner_nz_q <= owner_nz_d;
      bank_q     <= bank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

endmodule

// File: design/dhtk_back.sv
// ----------------------------------------------------------------------------
// dhtk_back
// Word store and emitter: walks one key's words into the result queue.
// ----------------------------------------------------------------------------
module dhtk_back #(
  parameter int unsigned ID_BYTES = dhtk_pkg::DefIdBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dhtk_pkg::wr_t     wr_i,
  input  logic              cmd_empty_i,
  input  dhtk_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  output logic              busy_o,
  input  logic              pop_i,
  output logic              empty_o,
  output dhtk_pkg::result_t result_o
);

  localparam int unsigned WordsPerId = (ID_BYTES + 7) / 8;
  localparam int unsigned TotalWords = 2 * WordsPerId;
  localparam int unsigned StoreWords = dhtk_pkg::NumBanks << dhtk_pkg::StoreAw;
  localparam int unsigned ResCntW    = $clog2(dhtk_pkg::ResDepth + 1);
  localparam logic [3:0]  LastK      = 4'(TotalWords - 1);

  typedef enum logic [1:0] {
    BkIdle = 2'b01,
    BkRun  = 2'b10
  } back_state_e;

  back_state_e         state_q, state_d;
  dhtk_pkg::cmd_t      cur_q, cur_d;
  logic [3:0]          k_q, k_d;
  logic                s_vld_q;
  logic                s_inv_q, s_inv_d;
  logic [2:0]          s_seq_q, s_seq_d;
  logic                s_last_q, s_last_d;
  logic [63:0]         rdata_q;
  logic [63:0]         store_q [StoreWords];
  logic                issue;
  logic [ResCntW-1:0]  res_count;
  dhtk_pkg::result_t   res_in;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      store_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rdata_q <= store_q[{cur_q.bank, k_q}];
    end
  end

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    k_d       = k_q;
    cmd_pop_o = 1'b0;
    issue     = 1'b0;
    s_inv_d   = s_inv_q;
    s_seq_d   = s_seq_q;
    s_last_d  = s_last_q;
    unique case (state_q)
      BkIdle: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          k_d       = 4'h0;
          state_d   = BkRun;
        end
      end
      BkRun: begin
        if ((ResCntW+1)'(res_count) + (ResCntW+1)'(s_vld_q)
            < (ResCntW+1)'(dhtk_pkg::ResDepth)) begin
          issue    = 1'b1;
          s_inv_d  = !cur_q.ok;
          s_seq_d  = cur_q.ok ? k_q[2:0] : 3'd0;
          s_last_d = !cur_q.ok || (k_q == LastK);
          if (s_last_d) begin
            state_d = BkIdle;
          end else begin
            k_d = 4'(k_q + 1'b1);
          end
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      s_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      s_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    k_q      <= k_d;
    s_inv_q  <= s_inv_d;
    s_seq_q  <= s_seq_d;
    s_last_q <= s_last_d;
  end

  assign busy_o = (state_q == BkRun);

  assign res_in = '{
    status:      s_inv_q ? dhtk_pkg::STATUS_INVALID : dhtk_pkg::STATUS_OK,
    word_seq:    s_seq_q,
    word:        s_inv_q ? 64'h0 : rdata_q,
    last_result: s_last_q
  };

  dhtk_fifo #(
    .Width ($bits(dhtk_pkg::result_t)),
    .Depth (dhtk_pkg::ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_vld_q),
    .wdata_i (res_in),
    .pop_i   (pop_i),
    .rdata_o (result_o),
    .empty_o (empty_o),
    .count_o (res_count)
  );

endmodule

// File: design/dht_key_hex_parser_top.sv
// ----------------------------------------------------------------------------
// dht_key_hex_parser_top
// Parses a key text into mesh hash and owner id words.
// ----------------------------------------------------------------------------
// One character is taken per cycle while full is low. When a key ends, its result beats (one
// invalid beat, or 2*ceil(ID_BYTES/8) words) leave one per cycle while there is
// room in the result queue. The word store holds two
// banks, so characters keep flowing while up to one finished key drains;
// full rises only while two finished keys still wait for their words to be
// read out of the store.
module dht_key_hex_parser_top #(
  parameter int unsigned ID_BYTES = dhtk_pkg::DefIdBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  dhtk_pkg::item_t   item_i,
  input  logic              pop,
  output logic              empty,
  output dhtk_pkg::result_t result_o
);

  localparam int unsigned CmdCntW = $clog2(dhtk_pkg::CmdDepth + 1);

  dhtk_pkg::wr_t   wr;
  dhtk_pkg::cmd_t  cmd_in, cmd_out;
  logic            take;
  logic            cmd_push, cmd_pop, cmd_empty, busy;
  logic [CmdCntW-1:0] cmd_count;

  assign full = ((CmdCntW+1)'(cmd_count) + (CmdCntW+1)'(busy))
                >= (CmdCntW+1)'(dhtk_pkg::NumBanks);
  assign take = push && !full;

  dhtk_front #(.ID_BYTES(ID_BYTES)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .item_i     (item_i),
    .wr_o       (wr),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  dhtk_fifo #(
    .Width ($bits(dhtk_pkg::cmd_t)),
    .Depth (dhtk_pkg::CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty),
    .count_o (cmd_count)
  );

  dhtk_back #(.ID_BYTES(ID_BYTES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .busy_o      (busy),
    .pop_i       (pop),
    .empty_o     (empty),
    .result_o    (result_o)
  );

  a_cmd_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> cmd_count < CmdCntW'(dhtk_pkg::CmdDepth))
    else $error("command queue overflow");

  a_store_write_only_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> take)
    else $error("store written without an accepted beat");

  a_invalid_beat_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.status == dhtk_pkg::STATUS_INVALID)
      |-> (result_o.word == 64'h0 && result_o.last_result))
    else $error("invalid beat carries data or is not final");

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: key hex parser regression
// Streams key texts into the parser, both well formed and broken ones. Keys
// are too short, too long, carry bad characters or have an all-zero id. A
// scoreboard class predicts the word beats of each key and checks every
// popped beat against them. Both sides idle at random, and the receiver
// stalls long enough to back the parser up.
// ----------------------------------------------------------------------------
module tb;
  import dhtk_pkg::*;

  localparam int unsigned IdBytes     = DefIdBytes;
  localparam int unsigned HexLen      = 2 * IdBytes;
  localparam int unsigned MeshStart   = PrefixLen;
  localparam int unsigned SepStart    = MeshStart + HexLen;
  localparam int unsigned OwnerStart  = SepStart + SepLen;
  localparam int unsigned KeyLen      = OwnerStart + HexLen;
  localparam int unsigned WordsPerId  = (IdBytes + 7) / 8;
  localparam int unsigned StoreWords  = 16;
  localparam int unsigned MaxReported = 10;
  localparam int unsigned HoldCycles  = 900;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned IdlePct     = 21;
  localparam int unsigned ItemTarget  = 410;

  localparam logic [8*PrefixLen-1:0] KeyPrefix = "mgmt:";
  localparam logic [8*SepLen-1:0]    KeySep    = ":node:";

  typedef enum int unsigned {
    KEY_VALID,
    KEY_BAD_CHAR,
    KEY_SHORT,
    KEY_LONG,
    KEY_ZERO_MESH,
    KEY_ZERO_OWNER,
    KEY_NOISE
  } key_kind_e;

  class key_scoreboard;
    result_t          expected[$];
    int unsigned      mismatches;
    int unsigned      predicted;
    int unsigned      pos;
    bit               bad;
    bit               mesh_nz;
    bit               owner_nz;
    logic [3:0]       high_nib;
    logic [63:0]      store [StoreWords];

    function new();
      mismatches = 0;
      predicted  = 0;
      clear_key();
    endfunction

    function void clear_key();
      pos      = 0;
      bad      = 1'b0;
      mesh_nz  = 1'b0;
      owner_nz = 1'b0;
      high_nib = 4'h0;
    endfunction

    function void take_digit(logic [7:0] c, int unsigned d, int unsigned id);
      logic [3:0]  v;
      logic [7:0]  b8;
      int unsigned b;
      int unsigned w;
      int unsigned sh;
      v = 4'h0;
      if (c >= 8'h30 && c <= 8'h39) begin
        v = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
        v = 4'(c - 8'h57);
      end else begin
        bad = 1'b1;
      end
      if (d % 2 == 0) begin
        high_nib = v;
      end else begin
        b  = d / 2;
        b8 = {high_nib, v};
        w  = (id * WordsPerId + b / 8) % StoreWords;
        sh = (7 - b % 8) * 8;
        if (b % 8 == 0) begin
          store[w] = 64'(b8) << sh;
        end else begin
          store[w] = store[w] | (64'(b8) << sh);
        end
        if (b8 != 8'h00) begin
          if (id == 0) mesh_nz = 1'b1;
          else owner_nz = 1'b1;
        end
      end
    endfunction

    function void note_char(item_t it);
      result_t     r;
      int unsigned p;
      int unsigned k;
      int unsigned total;
      p = pos;
      if (p >= KeyLen) begin
        bad = 1'b1;
      end else begin
        if (p < MeshStart) begin
          if (it.character != KeyPrefix[8*(PrefixLen-1-p) +: 8]) bad = 1'b1;
        end else if (p < SepStart) begin
          take_digit(it.character, p - MeshStart, 0);
        end else if (p < OwnerStart) begin
          if (it.character != KeySep[8*(SepLen-1-(p-SepStart)) +: 8]) bad = 1'b1;
        end else begin
          take_digit(it.character, p - OwnerStart, 1);
        end
        pos = p + 1;
      end
      if (!it.end_of_key) return;
      if (!bad && pos == KeyLen && mesh_nz && owner_nz) begin
        total = 2 * WordsPerId;
        for (k = 0; k < total; k++) begin
          r.status      = STATUS_OK;
          r.word_seq    = 3'(k % 8);
          r.word        = store[k % StoreWords];
          r.last_result = (k + 1 == total);
          expected.push_back(r);
        end
        predicted += total;
      end else begin
        r.status      = STATUS_INVALID;
        r.word_seq    = 3'd0;
        r.word        = 64'd0;
        r.last_result = 1'b1;
        expected.push_back(r);
        predicted += 1;
      end
      clear_key();
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (expected.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("unexpected beat: status %0b seq %0d word %h last %0b",
                   got.status, got.word_seq, got.word, got.last_result);
        return;
      end
      want = expected.pop_front();
      if (got.status !== want.status || got.word_seq !== want.word_seq ||
          got.word !== want.word || got.last_result !== want.last_result) begin
        mismatches++;
        if (mismatches <= MaxReported) begin
          $display("beat mismatch: expected status %0b seq %0d word %h last %0b",
                   want.status, want.word_seq, want.word, want.last_result);
          $display("               actual   status %0b seq %0d word %h last %0b",
                   got.status, got.word_seq, got.word, got.last_result);
        end
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          push;
  logic          full;
  item_t         item_i;
  logic          pop;
  logic          empty;
  result_t       result_o;
  bit            no_idle;
  bit            hold_req;
  int unsigned   cycles = 0;
  int unsigned   chars_sent = 0;
  key_scoreboard sb;

  dht_key_hex_parser_top #(.ID_BYTES(IdBytes)) dut (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .item_i,
    .pop,
    .empty,
    .result_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] v);
    return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h57 + 8'(v);
  endfunction

  function automatic logic [7:0] prefix_at(int unsigned i);
    return KeyPrefix[8*(PrefixLen-1-i) +: 8];
  endfunction

  function automatic logic [7:0] sep_at(int unsigned i);
    return KeySep[8*(SepLen-1-i) +: 8];
  endfunction

  function automatic key_kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return KEY_VALID;
    if (r < 65) return KEY_BAD_CHAR;
    if (r < 75) return KEY_SHORT;
    if (r < 82) return KEY_LONG;
    if (r < 88) return KEY_ZERO_MESH;
    if (r < 94) return KEY_ZERO_OWNER;
    return KEY_NOISE;
  endfunction

  task automatic send_char(logic [7:0] c, logic last);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push   <= 1'b1;
    item_i <= item_t'{character: c, end_of_key: last};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_char(item_i);
    chars_sent++;
  endtask

  task automatic send_key(key_kind_e kind);
    logic [7:0]  txt[$];
    int unsigned n;
    int unsigned spot;
    int unsigned i;
    txt = {};
    if (kind == KEY_NOISE) begin
      n = $urandom_range(1, 8);
      repeat (n) txt.push_back(8'($urandom));
    end else begin
      for (i = 0; i < PrefixLen; i++) txt.push_back(prefix_at(i));
      for (i = 0; i < HexLen; i++)
        txt.push_back(kind == KEY_ZERO_MESH ? 8'h30 : hex_char(4'($urandom)));
      for (i = 0; i < SepLen; i++) txt.push_back(sep_at(i));
      for (i = 0; i < HexLen; i++)
        txt.push_back(kind == KEY_ZERO_OWNER ? 8'h30 : hex_char(4'($urandom)));
      // drop a single nonzero digit into a zeroed id half the time
      if ((kind == KEY_ZERO_MESH || kind == KEY_ZERO_OWNER) && $urandom_range(1) == 1) begin
        spot = ((kind == KEY_ZERO_MESH) ? MeshStart : OwnerStart) + $urandom_range(HexLen - 1);
        txt[spot] = hex_char(4'($urandom_range(1, 15)));
      end
      case (kind)
        KEY_BAD_CHAR: begin
          spot = $urandom_range(KeyLen - 1);
          txt[spot] = ($urandom_range(1) == 1) ? 8'($urandom)
                                               : 8'(8'h41 + $urandom_range(5));
        end
        KEY_SHORT: begin
          n = $urandom_range(1, KeyLen - 1);
          while (txt.size() > n) void'(txt.pop_back());
        end
        KEY_LONG: begin
          repeat ($urandom_range(1, 5)) txt.push_back(8'($urandom));
        end
        default: begin
        end
      endcase
    end
    for (i = 0; i < txt.size(); i++) send_char(txt[i], i == txt.size() - 1);
  endtask

  task automatic pause_until_drained();
    push <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk_i);
  endtask

  initial begin : drain
    int unsigned hold_left;
    bit          hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) sb.check_word(result_o);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= no_idle || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  initial begin : stimulus
    int unsigned i;
    int unsigned keys;
    key_kind_e   kind;
    sb = new();
    rst_ni   <= 1'b0;
    push     <= 1'b0;
    item_i   <= '0;
    no_idle  <= 1'b0;
    hold_req <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_char(8'h00, 1'b1);
    send_char(8'hff, 1'b1);
    for (i = 0; i < PrefixLen; i++) send_char(prefix_at(i), i == PrefixLen - 1);
    for (i = 0; i < PrefixLen; i++) send_char(prefix_at(i), 1'b0);
    send_char(8'h30, 1'b0);
    send_char(8'h39, 1'b0);
    send_char(8'h61, 1'b0);
    send_char(8'h66, 1'b1);
    send_char(8'h3a, 1'b1);
    send_char(8'h4d, 1'b0);
    send_char(8'h6d, 1'b1);

    // hold the receiver while whole keys pile up
    hold_req <= 1'b1;
    send_key(KEY_VALID);
    repeat (4) send_key(KEY_NOISE);
    pause_until_drained();

    keys = 0;
    while (chars_sent < ItemTarget) begin
      no_idle <= (keys == 0);
      if (keys == 1) pause_until_drained();
      if (keys == 0) kind = KEY_VALID;
      else if (ItemTarget - chars_sent < KeyLen + 8) kind = KEY_NOISE;
      else kind = pick_kind();
      send_key(kind);
      keys++;
    end
    pause_until_drained();
    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
